// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

    localparam int MAX_FRAME_BYTES = 255;

    localparam logic [7:0] START_BYTE = 8'hFF;
    localparam logic [7:0] END_BYTE   = 8'hED;
    localparam logic [7:0] MIN_FRAME  = 8'd5;

    localparam logic [15:0] TIMEOUT_RESET = 16'd16;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_PAYLOAD = 3'd0;
    localparam t_kind KIND_OK      = 3'd1;
    localparam t_kind KIND_CHECK   = 3'd2;
    localparam t_kind KIND_FRAMING = 3'd3;
    localparam t_kind KIND_TIMEOUT = 3'd4;

endpackage

// ===== rtl/serial_frame_deframer_core.sv =====
// a result beat is registered and shown in the cycle after the input beat that causes it
// throughput: one input beat per cycle unless a result waits; the single frame-state update per beat
//   sits between the input handshake and the output register
// an output register decouples the sides, input stalls only while a result waits
// reset: synchronous active-low i_rst_n returns to hunting, clears the idle count
//   and the output valid, and loads timeout_ticks with 16
module serial_frame_deframer_core
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,     // timeout_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // payload_byte [7:0], payload_count [15:8]
    output logic [2:0]  m_axis_tuser    // kind
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [15:0] r_timeout;
    logic [1:0]  r_phase,  n_phase;
    logic [7:0]  r_len,    n_len;
    logic [7:0]  r_pos,    n_pos;
    logic [7:0]  r_sum,    n_sum;
    logic [15:0] r_idle,   n_idle;
    logic        r_tout,   n_tout;

    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_byte;
    logic [7:0]  r_out_count;

    logic        n_emit;
    t_kind       n_kind;
    logic [7:0]  n_byte;
    logic [7:0]  n_count;

    logic        accept;
    logic [7:0]  b;
    logic [8:0]  pos_p1;
    logic [8:0]  pos_p2;
    logic [15:0] idle_inc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign pos_p1        = {1'b0, r_pos} + 9'd1;
    assign pos_p2        = {1'b0, r_pos} + 9'd2;
    assign idle_inc      = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_idle  = r_idle;
        n_tout  = r_tout;
        n_emit  = 1'b0;
        n_kind  = KIND_PAYLOAD;
        n_byte  = 8'd0;
        n_count = 8'd0;
        if (s_axis_tuser == CMD_TICK) begin
            n_idle = idle_inc;
            if (idle_inc > r_timeout && !r_tout) begin
                n_tout  = 1'b1;
                n_phase = PH_HUNT;
                n_pos   = 8'd0;
                n_sum   = 8'd0;
                n_emit  = 1'b1;
                n_kind  = KIND_TIMEOUT;
            end
        end else begin
            n_idle = 16'd0;
            n_tout = 1'b0;
            if (r_phase == PH_LEN) begin
                n_len = b;
                n_sum = r_sum + b;
                n_pos = 8'd2;
                if (b < MIN_FRAME || b > 8'(MAX_FRAME_BYTES)) begin
                    n_phase = PH_HUNT;
                    n_emit  = 1'b1;
                    n_kind  = KIND_FRAMING;
                end else begin
                    n_phase = PH_BODY;
                end
            end else if (r_phase == PH_BODY) begin
                n_pos = pos_p1[7:0];
                if (pos_p1 >= {1'b0, r_len}) begin
                    n_phase = PH_HUNT;
                    n_emit  = 1'b1;
                    if (b != END_BYTE) begin
                        n_kind = KIND_FRAMING;
                    end else if (r_sum != 8'd0) begin
                        n_kind = KIND_CHECK;
                    end else begin
                        n_kind  = KIND_OK;
                        n_count = r_len - MIN_FRAME;
                    end
                end else if (pos_p2 == {1'b0, r_len}) begin
                    n_sum = r_sum - b;
                end else begin
                    n_sum = r_sum + b;
                    if (r_pos != 8'd2) begin
                        n_emit = 1'b1;
                        n_kind = KIND_PAYLOAD;
                        n_byte = b;
                    end
                end
            end else begin
                if (b == START_BYTE) begin
                    n_phase = PH_LEN;
                    n_sum   = START_BYTE;
                    n_pos   = 8'd1;
                    n_len   = 8'd0;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_phase     <= PH_HUNT;
            r_len       <= 8'd0;
            r_pos       <= 8'd0;
            r_sum       <= 8'd0;
            r_idle      <= 16'd0;
            r_tout      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_len       <= n_len;
                r_pos       <= n_pos;
                r_sum       <= n_sum;
                r_idle      <= n_idle;
                r_tout      <= n_tout;
                r_out_valid <= n_emit;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_kind  <= n_kind;
            r_out_byte  <= n_byte;
            r_out_count <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_count, r_out_byte};

endmodule

// ===== rtl/sfd_checker.sv =====
module sfd_checker
    import sfd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // stalled result beat holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // result kind is a defined code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= KIND_TIMEOUT)
        else $error("undefined result kind");

    // data byte only on payload beats, count only on ok beats
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD || m_axis_tdata[7:0] == 8'd0)
            && (m_axis_tuser == KIND_OK || m_axis_tdata[15:8] == 8'd0))
        else $error("result fields do not match kind");

    // no result beat without an input beat or a held result the cycle before
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result beat without an input beat");

endmodule

bind serial_frame_deframer_core sfd_checker u_sfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
